[hw/rtl/temperature_to_seven_segment_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the temperature to seven-segment block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TEMPERATURE_TO_SEVEN_SEGMENT_DEFINES_SVH
`define TEMPERATURE_TO_SEVEN_SEGMENT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define T2S_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset
`define T2S_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

[hw/rtl/t2s_pkg.sv]
// ----------------------------------------------------------------------------
// t2s_pkg
// Types, segment constants and decode tables for the temperature display.
// ----------------------------------------------------------------------------
`default_nettype none

package t2s_pkg;

    localparam int RAW_W  = 12;
    localparam int SEG_W  = 8;
    localparam int NUM_POS = 8;   // most digits one reading can show

    localparam logic [SEG_W-1:0] SEG_MINUS = 8'h40;
    localparam logic [SEG_W-1:0] SEG_DP    = 8'h80;
    localparam logic [SEG_W-1:0] SEL_FIRST = 8'hfe;

    // Sign and magnitude of one reading
    typedef struct packed {
        logic             neg;
        logic [RAW_W-1:0] mag;
    } t_mag_word;

    // Decimal digits and which leading ones are shown
    typedef struct packed {
        logic       neg;
        logic       show_h;
        logic       show_t;
        logic [3:0] hund;
        logic [3:0] tens;
        logic [3:0] unit;
        logic [3:0] f1;
        logic [3:0] f2;
        logic [3:0] f3;
        logic [3:0] f4;
    } t_dig_word;

    // Left-packed segment patterns with their count
    typedef struct packed {
        logic [NUM_POS-1:0][SEG_W-1:0] pats;
        logic [3:0]                    cnt;
    } t_pack_word;

    // Seven-segment pattern of a decimal digit
    function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:    s = 8'h3f;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h5b;
            4'd3:    s = 8'h4f;
            4'd4:    s = 8'h66;
            4'd5:    s = 8'h6d;
            4'd6:    s = 8'h7d;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'h7f;
            4'd9:    s = 8'h6f;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    // Four fraction digits of a sixteenth, as BCD of frac * 625
    function automatic logic [15:0] frac_bcd(input logic [3:0] f);
        logic [15:0] b;
        case (f)
            4'd0:    b = 16'h0000;
            4'd1:    b = 16'h0625;
            4'd2:    b = 16'h1250;
            4'd3:    b = 16'h1875;
            4'd4:    b = 16'h2500;
            4'd5:    b = 16'h3125;
            4'd6:    b = 16'h3750;
            4'd7:    b = 16'h4375;
            4'd8:    b = 16'h5000;
            4'd9:    b = 16'h5625;
            4'd10:   b = 16'h6250;
            4'd11:   b = 16'h6875;
            4'd12:   b = 16'h7500;
            4'd13:   b = 16'h8125;
            4'd14:   b = 16'h8750;
            4'd15:   b = 16'h9375;
            default: b = 16'h0000;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/t2s_magnitude.sv]
// ----------------------------------------------------------------------------
// t2s_magnitude
// First pipeline stage: splits the reading into sign and magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module t2s_magnitude (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_valid,
    output      logic                     o_ready,
    input  wire logic [t2s_pkg::RAW_W-1:0] i_raw,
    output      logic                     o_valid,
    input  wire logic                     i_ready,
    output      t2s_pkg::t_mag_word       o_word
);

    logic                r_vld;
    t2s_pkg::t_mag_word  r_word;
    t2s_pkg::t_mag_word  n_word;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_word  = r_word;

    // Negate in twelve bits; the most negative reading maps to 2048 itself
    always_comb begin
        n_word.neg = i_raw[t2s_pkg::RAW_W-1];
        n_word.mag = n_word.neg ? (~i_raw + 12'd1) : i_raw;
    end

    // Advance when the stage is free or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/t2s_decode.sv]
// ----------------------------------------------------------------------------
// t2s_decode
// Second pipeline stage: integer and fraction digits of the magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module t2s_decode (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output      logic               o_ready,
    input  wire t2s_pkg::t_mag_word i_word,
    output      logic               o_valid,
    input  wire logic               i_ready,
    output      t2s_pkg::t_dig_word o_word
);

    logic                r_vld;
    t2s_pkg::t_dig_word  r_word;
    t2s_pkg::t_dig_word  n_word;

    logic [7:0]  whole;
    logic        ge100;
    logic [7:0]  rem8;
    logic [6:0]  rem;
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  tens_x10;
    logic [6:0]  unit7;
    logic [15:0] fbcd;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_word  = r_word;

    // Whole degrees 0..128: hundreds by compare, tens by reciprocal of ten
    always_comb begin
        whole    = i_word.mag[11:4];
        ge100    = (whole >= 8'd100);
        rem8     = ge100 ? (whole - 8'd100) : whole;
        rem      = rem8[6:0];
        prod     = {8'd0, rem} * 15'd205;
        tens     = prod[14:11];
        tens_x10 = {3'd0, tens} * 7'd10;
        unit7    = rem - tens_x10;
        fbcd     = t2s_pkg::frac_bcd(i_word.mag[3:0]);

        n_word.neg    = i_word.neg;
        n_word.show_h = ge100;
        n_word.show_t = (whole >= 8'd10);
        n_word.hund   = {3'd0, ge100};
        n_word.tens   = tens;
        n_word.unit   = unit7[3:0];
        n_word.f1     = fbcd[15:12];
        n_word.f2     = fbcd[11:8];
        n_word.f3     = fbcd[7:4];
        n_word.f4     = fbcd[3:0];
    end

    // Advance when the stage is free or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/t2s_pack.sv]
// ----------------------------------------------------------------------------
// t2s_pack
// Third pipeline stage: selects the shown digits and packs them leftwards.
// ----------------------------------------------------------------------------
`default_nettype none

module t2s_pack (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output      logic                o_ready,
    input  wire t2s_pkg::t_dig_word  i_word,
    output      logic                o_valid,
    input  wire logic                i_ready,
    output      t2s_pkg::t_pack_word o_word
);

    logic                 r_vld;
    t2s_pkg::t_pack_word  r_word;
    t2s_pkg::t_pack_word  n_word;

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_word  = r_word;

    // Append each shown digit at the next free slot
    always_comb begin
        logic [3:0] k;
        k = 4'd0;
        n_word.pats = '0;
        if (i_word.neg) begin
            n_word.pats[k[2:0]] = t2s_pkg::SEG_MINUS;
            k = k + 4'd1;
        end
        if (i_word.show_h) begin
            n_word.pats[k[2:0]] = t2s_pkg::seg_of(i_word.hund);
            k = k + 4'd1;
        end
        if (i_word.show_t) begin
            n_word.pats[k[2:0]] = t2s_pkg::seg_of(i_word.tens);
            k = k + 4'd1;
        end
        n_word.pats[k[2:0]] = t2s_pkg::seg_of(i_word.unit) | t2s_pkg::SEG_DP;
        k = k + 4'd1;
        n_word.pats[k[2:0]] = t2s_pkg::seg_of(i_word.f1);
        k = k + 4'd1;
        // Drop trailing zeros of the fraction
        if (!(i_word.f2 == 4'd0 && i_word.f3 == 4'd0)) begin
            n_word.pats[k[2:0]] = t2s_pkg::seg_of(i_word.f2);
            k = k + 4'd1;
        end
        if (!(i_word.f3 == 4'd0 && i_word.f4 == 4'd0)) begin
            n_word.pats[k[2:0]] = t2s_pkg::seg_of(i_word.f3);
            k = k + 4'd1;
        end
        if (i_word.f4 != 4'd0) begin
            n_word.pats[k[2:0]] = t2s_pkg::seg_of(i_word.f4);
            k = k + 4'd1;
        end
        n_word.cnt = k;
    end

    // Advance when the stage is free or being drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_word <= n_word;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/t2s_serial.sv]
// ----------------------------------------------------------------------------
// t2s_serial
// Output stage: shifts the packed digits out one word per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module t2s_serial (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output      logic                      o_ready,
    input  wire t2s_pkg::t_pack_word       i_word,
    output      logic                      o_valid,
    input  wire logic                      i_ready,
    output      logic [t2s_pkg::SEG_W-1:0] o_segments,
    output      logic [t2s_pkg::SEG_W-1:0] o_digit_select,
    output      logic                      o_last_digit
);

    logic [t2s_pkg::NUM_POS-1:0][t2s_pkg::SEG_W-1:0] r_pats;
    logic [3:0]                                      r_left;
    logic [t2s_pkg::SEG_W-1:0]                       r_sel;
    logic                                            take;

    // Load a new reading once the last digit of the current one goes
    assign o_ready = (r_left == 4'd0) || (r_left == 4'd1 && i_ready);
    assign take    = o_valid && i_ready;

    assign o_valid        = (r_left != 4'd0);
    assign o_segments     = r_pats[0];
    assign o_digit_select = r_sel;
    assign o_last_digit   = (r_left == 4'd1);

    // Hold on stall, shift on each accepted word, reload at the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 4'd0;
        end else if (o_ready) begin
            r_left <= i_valid ? i_word.cnt : 4'd0;
        end else if (take) begin
            r_left <= r_left - 4'd1;
        end
        if (o_ready && i_valid) begin
            r_pats <= i_word.pats;
            r_sel  <= t2s_pkg::SEL_FIRST;
        end else if (take) begin
            r_pats <= r_pats >> t2s_pkg::SEG_W;
            r_sel  <= {r_sel[t2s_pkg::SEG_W-2:0], 1'b1};
        end
    end

endmodule

`default_nettype wire

[hw/rtl/temperature_to_seven_segment.sv]
// A reading's first digit word is offered once it has passed the magnitude, decode and pack registers.
// Throughput: one digit word per cycle while the receiver is ready; a reading
// gives 2 to 8 words, so the output shifter sets the sustained reading rate.
// The three decode stages take a new reading in every cycle while free.
// Reset (synchronous, active low) empties all stages; no word is pending.
// ----------------------------------------------------------------------------
// temperature_to_seven_segment
// Signed sixteenth-degree reading to left-packed seven-segment digit words.
// ----------------------------------------------------------------------------
`default_nettype none

module temperature_to_seven_segment (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output      logic                      o_ready,
    input  wire logic [t2s_pkg::RAW_W-1:0] i_temperature_raw,
    output      logic                      o_valid,
    input  wire logic                      i_ready,
    output      logic [t2s_pkg::SEG_W-1:0] o_segments,
    output      logic [t2s_pkg::SEG_W-1:0] o_digit_select,
    output      logic                      o_last_digit
);

    logic                m_valid, m_ready;
    t2s_pkg::t_mag_word  m_word;
    logic                d_valid, d_ready;
    t2s_pkg::t_dig_word  d_word;
    logic                p_valid, p_ready;
    t2s_pkg::t_pack_word p_word;

    // Sign and magnitude
    t2s_magnitude u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_raw   (i_temperature_raw),
        .o_valid (m_valid),
        .i_ready (m_ready),
        .o_word  (m_word)
    );

    // Decimal digits
    t2s_decode u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (m_valid),
        .o_ready (m_ready),
        .i_word  (m_word),
        .o_valid (d_valid),
        .i_ready (d_ready),
        .o_word  (d_word)
    );

    // Digit selection and packing
    t2s_pack u_pack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d_valid),
        .o_ready (d_ready),
        .i_word  (d_word),
        .o_valid (p_valid),
        .i_ready (p_ready),
        .o_word  (p_word)
    );

    // Word-per-cycle output while the receiver is ready
    t2s_serial u_ser (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (p_valid),
        .o_ready        (p_ready),
        .i_word         (p_word),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_segments     (o_segments),
        .o_digit_select (o_digit_select),
        .o_last_digit   (o_last_digit)
    );

endmodule

`default_nettype wire

[hw/rtl/t2s_checker.sv]
// ----------------------------------------------------------------------------
// t2s_checker
// Port-level checks on the digit word stream of the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "temperature_to_seven_segment_defines.svh"

module t2s_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [7:0] o_segments,
    input wire logic [7:0] o_digit_select,
    input wire logic       o_last_digit
);

    logic out_take;
    assign out_take = o_valid && i_ready;

    // A stalled word holds
    `T2S_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_segments) && $stable(o_digit_select) && $stable(o_last_digit))

    // Exactly one position is selected
    `T2S_ASSERT_IMPLY(a_onehot, i_clk, i_rst_n, o_valid, $onehot(~o_digit_select))

    // Words of one reading follow without a gap, one position further on
    `T2S_ASSERT_NEXT(a_advance, i_clk, i_rst_n, out_take && !o_last_digit, o_valid && (o_digit_select == {$past(o_digit_select[6:0]), 1'b1}))

    // A new reading starts at the first position
    `T2S_ASSERT_NEXT(a_restart, i_clk, i_rst_n, out_take && o_last_digit, !o_valid || (o_digit_select == 8'hfe))

endmodule

bind temperature_to_seven_segment t2s_checker u_t2s_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_segments     (o_segments),
    .o_digit_select (o_digit_select),
    .o_last_digit   (o_last_digit)
);

`default_nettype wire

[dv/tb_temperature_to_seven_segment.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_temperature_to_seven_segment
// Drives signed sixteenth-degree readings into the display block and checks
// every digit word against a local decimal predictor. Both handshakes idle at
// random, with calm stretches and one long output hold-off.
// ----------------------------------------------------------------------------

module tb_temperature_to_seven_segment;

    localparam int CLK_PERIOD   = 12;
    localparam int RST_CYCLES   = 6;
    localparam int MAX_GAP      = 17;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AT_WORD = 150;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_CHUNK = 50;
    localparam int NUM_CHUNKS   = 4;

    localparam int RAW_W = t2s_pkg::RAW_W;
    localparam int SEG_W = t2s_pkg::SEG_W;
    localparam logic [SEG_W-1:0] SEG_MINUS = t2s_pkg::SEG_MINUS;
    localparam logic [SEG_W-1:0] SEG_DP    = t2s_pkg::SEG_DP;

    // Digit patterns 0..9, segment a in bit 0
    localparam logic [SEG_W-1:0] DIGIT_FONT [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    typedef struct packed {
        logic [SEG_W-1:0] segments;
        logic [SEG_W-1:0] select;
        logic             last;
    } t_digit_word;

    logic                 i_clk             = 1'b0;
    logic                 i_rst_n           = 1'b0;
    logic                 i_valid           = 1'b0;
    logic                 o_ready;
    logic [RAW_W-1:0]     i_temperature_raw = '0;
    logic                 o_valid;
    logic                 i_ready           = 1'b0;
    logic [SEG_W-1:0]     o_segments;
    logic [SEG_W-1:0]     o_digit_select;
    logic                 o_last_digit;

    logic [RAW_W-1:0]     pending_readings [$];
    t_digit_word          digits_due [$];
    logic                 reading_taken = 1'b0;
    logic                 word_taken    = 1'b0;
    logic                 calm          = 1'b0;
    int                   send_gap      = 0;
    int                   rx_stall      = 0;
    int                   hold_left     = 0;
    logic                 hold_done     = 1'b0;
    int                   words_seen    = 0;
    int                   mismatches    = 0;
    int                   cycle_count   = 0;

    temperature_to_seven_segment dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_temperature_raw (i_temperature_raw),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_segments        (o_segments),
        .o_digit_select    (o_digit_select),
        .o_last_digit      (o_last_digit)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Idle length for one word; none during calm stretches
    function automatic int pick_gap();
        return calm ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // Work out the digit words one reading should produce
    function automatic void predict_digits(input logic [RAW_W-1:0] raw);
        logic             neg;
        logic [RAW_W-1:0] mag;
        int               scaled;
        logic [SEG_W-1:0] pats [$];
        t_digit_word      w;
        int               f2, f3, f4;
        neg = raw[RAW_W-1];
        // 12-bit negation leaves 2048 for the most negative reading
        mag = neg ? (~raw + 1'b1) : raw;
        scaled = int'(mag) * 625;
        f2 = (scaled % 1000) / 100;
        f3 = (scaled % 100) / 10;
        f4 = scaled % 10;
        if (neg)
            pats.push_back(SEG_MINUS);
        if (scaled >= 1000000)
            pats.push_back(DIGIT_FONT[(scaled / 1000000) % 10]);
        if (scaled >= 100000)
            pats.push_back(DIGIT_FONT[(scaled % 1000000) / 100000]);
        pats.push_back(DIGIT_FONT[(scaled % 100000) / 10000] | SEG_DP);
        pats.push_back(DIGIT_FONT[(scaled % 10000) / 1000]);
        // Trailing fraction zeros are dropped
        if (f2 != 0 || f3 != 0)
            pats.push_back(DIGIT_FONT[f2]);
        if (f3 != 0 || f4 != 0)
            pats.push_back(DIGIT_FONT[f3]);
        if (f4 != 0)
            pats.push_back(DIGIT_FONT[f4]);
        foreach (pats[k]) begin
            w.segments = pats[k];
            w.select   = ~(8'd1 << k);
            w.last     = (k == pats.size() - 1);
            digits_due.push_back(w);
        end
    endfunction

    // Sender: hold the word until taken, then idle and offer the next
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !reading_taken) begin
                // hold
            end else if (send_gap != 0) begin
                i_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_readings.size() != 0) begin
                i_temperature_raw <= pending_readings.pop_front();
                i_valid           <= 1'b1;
                send_gap          <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: may stall after each word, with one long hold-off to back up the block
    always @(negedge i_clk) begin
        int stall;
        if (i_rst_n) begin
            if (hold_left != 0) begin
                i_ready   <= 1'b0;
                hold_left <= hold_left - 1;
            end else if (!hold_done && words_seen >= HOLD_AT_WORD) begin
                i_ready   <= 1'b0;
                hold_done <= 1'b1;
                hold_left <= LONG_HOLD;
            end else if (word_taken) begin
                stall = pick_gap();
                if (stall == 0) begin
                    i_ready <= 1'b1;
                end else begin
                    i_ready  <= 1'b0;
                    rx_stall <= stall - 1;
                end
            end else if (rx_stall != 0) begin
                i_ready  <= 1'b0;
                rx_stall <= rx_stall - 1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Monitor: check each digit word, then predict from each accepted reading
    always @(posedge i_clk) begin
        t_digit_word exp_word;
        int          errs;
        errs = 0;
        if (i_rst_n) begin
            reading_taken <= i_valid && o_ready;
            word_taken    <= o_valid && i_ready;
            if (o_valid && i_ready) begin
                words_seen <= words_seen + 1;
                if (digits_due.size() == 0) begin
                    $error("unexpected digit word: segments %h select %h last %b",
                           o_segments, o_digit_select, o_last_digit);
                    errs = errs + 1;
                end else begin
                    exp_word = digits_due.pop_front();
                    if (o_segments !== exp_word.segments) begin
                        $error("segments: expected %h, got %h",
                               exp_word.segments, o_segments);
                        errs = errs + 1;
                    end
                    if (o_digit_select !== exp_word.select) begin
                        $error("digit_select: expected %h, got %h",
                               exp_word.select, o_digit_select);
                        errs = errs + 1;
                    end
                    if (o_last_digit !== exp_word.last) begin
                        $error("last_digit: expected %b, got %b",
                               exp_word.last, o_last_digit);
                        errs = errs + 1;
                    end
                end
            end
            if (errs != 0)
                mismatches <= mismatches + errs;
            if (i_valid && o_ready)
                predict_digits(i_temperature_raw);
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Stimulus: directed corners, then random chunks alternating calm and idling
    initial begin
        int               thresholds [3];
        int               t;
        logic [RAW_W-1:0] raw;
        thresholds = '{16, 160, 1600};
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero, single steps, fraction patterns and the blanking boundaries
        pending_readings = '{
            12'd0, 12'd1, -12'sd1, 12'd2, 12'd3, 12'd4, 12'd6, 12'd8, 12'd10,
            12'd12, 12'd15, 12'd16, -12'sd16, 12'd159, 12'd160, -12'sd159,
            -12'sd160, 12'd1599, 12'd1600, -12'sd1599, -12'sd1600, 12'd2000,
            12'd2047, -12'sd2047, 12'h800
        };
        while (pending_readings.size() != 0) @(negedge i_clk);

        for (int c = 0; c < NUM_CHUNKS; c++) begin
            calm <= (c % 2 == 1);
            for (int n = 0; n < RANDOM_CHUNK; n++) begin
                case ($urandom_range(0, 3))
                    0: raw = RAW_W'($urandom_range(0, 4095));
                    1: begin
                        t = thresholds[$urandom_range(0, 2)] + $urandom_range(0, 6) - 3;
                        raw = $urandom_range(0, 1) ? RAW_W'(-t) : RAW_W'(t);
                    end
                    2: raw = RAW_W'($urandom_range(0, 63)) - RAW_W'(32);
                    default: raw = {RAW_W'($urandom_range(0, 255)) << 4}
                                   | RAW_W'($urandom_range(0, 15));
                endcase
                pending_readings.push_back(raw);
            end
            while (pending_readings.size() != 0) @(negedge i_clk);
        end

        // Drain: let the last pop settle, then wait for every reading and word
        @(negedge i_clk);
        while (pending_readings.size() != 0 || (i_valid && !reading_taken)
               || digits_due.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/t2s_pkg.sv
hw/rtl/t2s_magnitude.sv
hw/rtl/t2s_decode.sv
hw/rtl/t2s_pack.sv
hw/rtl/t2s_serial.sv
hw/rtl/temperature_to_seven_segment.sv
hw/rtl/t2s_checker.sv
dv/tb_temperature_to_seven_segment.sv
